// ----- rtl/papl_pkg.sv -----
// Shared types and constants for the parabolic peak locator.
`default_nettype none
package papl_pkg;

	// Field widths fixed by the item format
	localparam int COORD_W = 32;
	localparam int MAG_W   = 31;
	localparam int NODE_W  = 16;
	localparam int STAT_W  = 2;

	// Vertex arithmetic widths
	localparam int ACC_D_W = 66;   // signed a*p - b*q
	localparam int ACC_N_W = 98;   // signed a*a*p - b*b*q
	localparam int NUM_W   = 97;   // |N|
	localparam int DEN_W   = 65;   // 2*|D|
	localparam int OFF_W   = 34;   // offset clamp range, up to 2^33
	localparam int LOC_W   = 36;   // x2 +/- offset before saturation

	localparam logic [OFF_W-1:0] OFF_MAX = {1'b1, {(OFF_W-1){1'b0}}};
	localparam logic signed [COORD_W-1:0] LOC_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] LOC_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_WIN_EN   = 2'd0,
		REG_WIN_LOW  = 2'd1,
		REG_WIN_HIGH = 2'd2
	} reg_idx_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_INTERP   = 2'd0,
		ST_END_NODE = 2'd1,
		ST_ZERO_DEN = 2'd2
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_SCAN,
		S_PREP,
		S_MUL,
		S_ACC,
		S_DSET,
		S_DIV,
		S_FIN,
		S_DONE
	} state_t;

	// Multiply steps of the shared unit
	typedef enum logic [2:0] {
		OP_AP    = 3'd0,   // |a|*|p|
		OP_BQ    = 3'd1,   // |b|*|q|
		OP_NA_LO = 3'd2,   // |a| * low word of |a||p|
		OP_NA_HI = 3'd3,   // |a| * high word of |a||p|
		OP_NB_LO = 3'd4,   // |b| * low word of |b||q|
		OP_NB_HI = 3'd5    // |b| * high word of |b||q|
	} op_t;

	// Absolute value, most negative input saturates to the largest positive value
	function automatic logic [MAG_W-1:0] sat_abs(input logic signed [COORD_W-1:0] v);
		logic [COORD_W-1:0] n;
		begin
			n = v[COORD_W-1] ? (~v + 32'd1) : v;
			if (v == LOC_MIN)
				sat_abs = {MAG_W{1'b1}};
			else
				sat_abs = n[MAG_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// ----- rtl/peak_abs_parabolic_locator_unit.sv -----
// Peak finder over a streamed mesh with three-point parabolic vertex interpolation.
//
//  channel  | dir | signals                         | payload
//  ---------+-----+---------------------------------+---------------------------------
//  s_axis   | in  | tvalid tready tdata[63:0] tlast | node_coord, sample_value; last_node
//  m_axis   | out | tvalid tready tdata[55:0]       | peak_location, peak_node, status
//  cfg      | in  | cfg_wr_en cfg_index cfg_data    | window_enable, window_low/high
//
//  Nodes are taken one per cycle while the sequencer scans; the search update is
//  combinational compare logic, registered as each node is taken. After a last node,
//  an end-node peak goes straight to the result; otherwise six 32x32 multiplies run
//  through one shared multiplier and accumulator, a zero denominator ends there, and
//  else a 97-step restoring divider follows at one quotient bit per cycle.
//  The result sits in an output register, so the next mesh streams in while it waits.
//  Reset clears the search, the window registers and the sequencer; no clearing pass.
`default_nettype none
module peak_abs_parabolic_locator_unit
	import papl_pkg::*;
#(
	parameter int MAX_NODES = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave item stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [31:0] node_coord, [63:32] sample_value
	input  wire logic        s_axis_tlast,   // last_node
	// master item stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,   // [31:0] peak_location, [47:32] peak_node,
	                                         // [49:48] peak_status, [55:50] zero
	// configuration writes
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int DCNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_NODES);
	localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(NUM_W - 1);

	// ---------------- configuration ----------------
	logic                      win_en_q;
	logic signed [COORD_W-1:0] win_lo_q, win_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_en_q <= 1'b0;
			win_lo_q <= LOC_MIN;
			win_hi_q <= LOC_MAX;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_WIN_EN:   win_en_q <= cfg_data[0];
				REG_WIN_LOW:  win_lo_q <= cfg_data;
				REG_WIN_HIGH: win_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- state ----------------
	state_t state_q, state_d;

	logic [CNT_W-1:0]          cnt_q;
	logic [MAG_W-1:0]          best_mag_q;
	logic [IDX_W-1:0]          best_node_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_v_q;
	logic signed [COORD_W-1:0] tx0_q, tx1_q, tx2_q, tv0_q, tv1_q, tv2_q;
	logic                      pend_q;

	// ---------------- search update ----------------
	logic signed [COORD_W-1:0] in_x, in_v;
	logic [MAG_W-1:0]          in_mag;
	logic                      in_ok, in_inside, in_take, in_acc;
	logic [CNT_W-1:0]          cnt_nx, last_idx;
	logic [MAG_W-1:0]          best_mag_nx;
	logic [IDX_W-1:0]          best_node_nx;
	logic signed [COORD_W-1:0] tx0_nx, tx1_nx, tx2_nx, tv0_nx, tv1_nx, tv2_nx;
	logic                      pend_nx, end_nx;

	assign in_x   = s_axis_tdata[31:0];
	assign in_v   = s_axis_tdata[63:32];
	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		in_mag    = sat_abs(in_v);
		in_ok     = cnt_q < CNT_MAX;
		in_inside = !win_en_q || (in_x >= win_lo_q && in_x <= win_hi_q);
		in_take   = in_ok && in_inside && (in_mag > best_mag_q);
		cnt_nx       = cnt_q;
		best_mag_nx  = best_mag_q;
		best_node_nx = best_node_q;
		tx0_nx = tx0_q; tx1_nx = tx1_q; tx2_nx = tx2_q;
		tv0_nx = tv0_q; tv1_nx = tv1_q; tv2_nx = tv2_q;
		pend_nx = pend_q;
		if (in_ok) begin
			if (cnt_q == '0) begin
				tx1_nx = in_x;
				tv1_nx = in_v;
			end
			if (in_take) begin
				best_mag_nx  = in_mag;
				best_node_nx = cnt_q[IDX_W-1:0];
				tx0_nx = prev_x_q; tv0_nx = prev_v_q;
				tx1_nx = in_x;     tv1_nx = in_v;
				pend_nx = 1'b1;
			end else if (pend_q) begin
				tx2_nx = in_x; tv2_nx = in_v;
				pend_nx = 1'b0;
			end
			cnt_nx = cnt_q + 1'b1;
		end
		last_idx = cnt_nx - 1'b1;
		end_nx   = (best_node_nx == '0) || (CNT_W'(best_node_nx) == last_idx);
	end

	// search registers, cleared after each last node
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; best_mag_q <= '0; best_node_q <= '0;
			prev_x_q <= '0; prev_v_q <= '0;
			tx0_q <= '0; tx1_q <= '0; tx2_q <= '0;
			tv0_q <= '0; tv1_q <= '0; tv2_q <= '0;
			pend_q <= 1'b0;
		end else if (in_acc) begin
			if (s_axis_tlast) begin
				cnt_q <= '0; best_mag_q <= '0; best_node_q <= '0;
				prev_x_q <= '0; prev_v_q <= '0;
				tx0_q <= '0; tx1_q <= '0; tx2_q <= '0;
				tv0_q <= '0; tv1_q <= '0; tv2_q <= '0;
				pend_q <= 1'b0;
			end else begin
				cnt_q <= cnt_nx; best_mag_q <= best_mag_nx; best_node_q <= best_node_nx;
				if (in_ok) begin
					prev_x_q <= in_x; prev_v_q <= in_v;
				end
				tx0_q <= tx0_nx; tx1_q <= tx1_nx; tx2_q <= tx2_nx;
				tv0_q <= tv0_nx; tv1_q <= tv1_nx; tv2_q <= tv2_nx;
				pend_q <= pend_nx;
			end
		end
	end

	// ---------------- vertex datapath ----------------
	logic signed [COORD_W-1:0] cx1_q, cx2_q, cx3_q;
	logic [MAG_W-1:0]          cf1_q, cf2_q, cf3_q;
	logic [IDX_W-1:0]          cbest_q;
	logic                      cend_q;

	logic [31:0] ma_q, mb_q, mp_q, mq_q;
	logic        sa_q, sb_q, sp_q, sq_q;
	op_t         op_q;
	logic [63:0] prod_q, ap_q, bq_q;
	logic signed [ACC_D_W-1:0] acc_d_q;
	logic signed [ACC_N_W-1:0] acc_n_q;

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  dv_q, rem_q;
	logic [OFF_W-1:0]  quo_q;
	logic              ovf_q, qneg_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic signed [COORD_W-1:0] res_loc_q;
	status_t                   res_stat_q;

	// operand differences for the prep step
	logic signed [COORD_W:0] a_w, b_w, a_abs, b_abs;
	logic signed [COORD_W-1:0] p_w, q_w, p_abs, q_abs;
	always_comb begin
		a_w   = {cx2_q[COORD_W-1], cx2_q} - {cx1_q[COORD_W-1], cx1_q};
		b_w   = {cx2_q[COORD_W-1], cx2_q} - {cx3_q[COORD_W-1], cx3_q};
		a_abs = a_w[COORD_W] ? -a_w : a_w;
		b_abs = b_w[COORD_W] ? -b_w : b_w;
		p_w   = {1'b0, cf2_q} - {1'b0, cf3_q};
		q_w   = {1'b0, cf2_q} - {1'b0, cf1_q};
		p_abs = p_w[COORD_W-1] ? -p_w : p_w;
		q_abs = q_w[COORD_W-1] ? -q_w : q_w;
	end

	// shared multiplier operand select and accumulator term
	logic [31:0]        mul_a, mul_b;
	logic               term_neg, term_hi, term_to_n;
	logic [ACC_N_W-1:0] term_n;
	always_comb begin
		mul_a = ma_q; mul_b = mp_q;
		term_neg = 1'b0; term_hi = 1'b0; term_to_n = 1'b1;
		case (op_q)
			OP_AP:    begin mul_a = ma_q; mul_b = mp_q; term_neg = sa_q ^ sp_q; term_to_n = 1'b0; end
			OP_BQ:    begin mul_a = mb_q; mul_b = mq_q; term_neg = !(sb_q ^ sq_q); term_to_n = 1'b0; end
			OP_NA_LO: begin mul_a = ma_q; mul_b = ap_q[31:0];  term_neg = sp_q; end
			OP_NA_HI: begin mul_a = ma_q; mul_b = ap_q[63:32]; term_neg = sp_q; term_hi = 1'b1; end
			OP_NB_LO: begin mul_a = mb_q; mul_b = bq_q[31:0];  term_neg = !sq_q; end
			OP_NB_HI: begin mul_a = mb_q; mul_b = bq_q[63:32]; term_neg = !sq_q; term_hi = 1'b1; end
			default: ;
		endcase
		term_n = term_hi ? {2'b0, prod_q, 32'b0} : {34'b0, prod_q};
	end

	// restoring divider step
	logic [DEN_W:0] r_try, r_sub;
	logic           r_ge;
	always_comb begin
		r_try = {rem_q, num_q[NUM_W-1]};
		r_ge  = r_try >= {1'b0, dv_q};
		r_sub = r_try - {1'b0, dv_q};
	end

	// magnitudes and final location
	logic [ACC_N_W-1:0]      n_abs;
	logic [ACC_D_W-1:0]      d_abs;
	logic [OFF_W-1:0]        off;
	logic signed [LOC_W-1:0] x2_e, off_e, loc_w;
	logic signed [COORD_W-1:0] loc_sat;
	always_comb begin
		n_abs = acc_n_q[ACC_N_W-1] ? -acc_n_q : acc_n_q;
		d_abs = acc_d_q[ACC_D_W-1] ? -acc_d_q : acc_d_q;
		off   = (ovf_q || quo_q > OFF_MAX) ? OFF_MAX : quo_q;
		x2_e  = LOC_W'(cx2_q);
		off_e = {{(LOC_W-OFF_W){1'b0}}, off};
		loc_w = qneg_q ? (x2_e + off_e) : (x2_e - off_e);
		if (loc_w > LOC_W'(LOC_MAX))
			loc_sat = LOC_MAX;
		else if (loc_w < LOC_W'(LOC_MIN))
			loc_sat = LOC_MIN;
		else
			loc_sat = loc_w[COORD_W-1:0];
	end

	// vertex registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_SCAN: begin
				if (in_acc && s_axis_tlast) begin
					cx1_q <= tx0_nx; cx2_q <= tx1_nx; cx3_q <= tx2_nx;
					cf1_q <= sat_abs(tv0_nx);
					cf2_q <= sat_abs(tv1_nx);
					cf3_q <= sat_abs(tv2_nx);
					cbest_q <= best_node_nx;
					cend_q  <= end_nx;
				end
			end
			S_PREP: begin
				ma_q <= a_abs[31:0]; sa_q <= a_w[COORD_W];
				mb_q <= b_abs[31:0]; sb_q <= b_w[COORD_W];
				mp_q <= p_abs;       sp_q <= p_w[COORD_W-1];
				mq_q <= q_abs;       sq_q <= q_w[COORD_W-1];
				acc_d_q <= '0;
				acc_n_q <= '0;
				op_q    <= OP_AP;
				res_loc_q  <= cx2_q;
				res_stat_q <= ST_END_NODE;
			end
			S_MUL: prod_q <= {32'b0, mul_a} * {32'b0, mul_b};
			S_ACC: begin
				if (term_to_n)
					acc_n_q <= term_neg ? (acc_n_q - term_n) : (acc_n_q + term_n);
				else
					acc_d_q <= term_neg ? (acc_d_q - ACC_D_W'(prod_q))
					                    : (acc_d_q + ACC_D_W'(prod_q));
				if (op_q == OP_AP) ap_q <= prod_q;
				if (op_q == OP_BQ) bq_q <= prod_q;
				op_q <= op_t'(op_q + 3'd1);
			end
			S_DSET: begin
				num_q  <= n_abs[NUM_W-1:0];
				dv_q   <= {d_abs[DEN_W-2:0], 1'b0};
				rem_q  <= '0;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
				dcnt_q <= '0;
				qneg_q <= acc_n_q[ACC_N_W-1] ^ acc_d_q[ACC_D_W-1];
				res_stat_q <= ST_ZERO_DEN;
				res_loc_q  <= (!acc_n_q[ACC_N_W-1] && acc_n_q != '0) ? LOC_MIN : LOC_MAX;
			end
			S_DIV: begin
				rem_q  <= r_ge ? r_sub[DEN_W-1:0] : r_try[DEN_W-1:0];
				num_q  <= {num_q[NUM_W-2:0], 1'b0};
				quo_q  <= {quo_q[OFF_W-2:0], r_ge};
				ovf_q  <= ovf_q | quo_q[OFF_W-1];
				dcnt_q <= dcnt_q + 1'b1;
			end
			S_FIN: begin
				res_loc_q  <= loc_sat;
				res_stat_q <= ST_INTERP;
			end
			default: ;
		endcase
	end

	// ---------------- sequencer ----------------
	logic out_free;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_SCAN;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		case (state_q)
			S_SCAN: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && s_axis_tlast) state_d = S_PREP;
			end
			S_PREP: state_d = cend_q ? S_DONE : S_MUL;
			S_MUL:  state_d = S_ACC;
			S_ACC:  state_d = (op_q == OP_NB_HI) ? S_DSET : S_MUL;
			S_DSET: state_d = (acc_d_q == '0) ? S_DONE : S_DIV;
			S_DIV:  state_d = (dcnt_q == DCNT_LAST) ? S_FIN : S_DIV;
			S_FIN:  state_d = S_DONE;
			S_DONE: if (out_free) state_d = S_SCAN;
			default: state_d = S_SCAN;
		endcase
	end

	// ---------------- output register ----------------
	logic signed [COORD_W-1:0] out_loc_q;
	logic [NODE_W-1:0]         out_node_q;
	status_t                   out_stat_q;
	logic                      out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_DONE && out_free)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_loc_q  <= res_loc_q;
			out_node_q <= NODE_W'(cbest_q);
			out_stat_q <= res_stat_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_stat_q, out_node_q, out_loc_q};

	// ---------------- assertions ----------------
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
		else $error("input taken right after a last node");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("node counter beyond mesh limit");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < dv_q))
		else $error("divider remainder not below divisor");

	a_zero_den_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_stat_q == ST_ZERO_DEN) |->
		(out_loc_q == LOC_MAX || out_loc_q == LOC_MIN))
		else $error("zero denominator result not saturated");

endmodule
`default_nettype wire

// ----- tb/tb_peak_abs_parabolic_locator_unit.sv -----
// Self-checking testbench for the streamed parabolic peak locator.
`timescale 1ns / 1ps
module tb_peak_abs_parabolic_locator_unit;
	import papl_pkg::*;

	localparam int NODE_LIMIT   = 65536;
	localparam int LONG_MESH    = 200;
	localparam int SETTLE_CYCLES = 140;     // longer than the vertex divide
	localparam int HOLD_CYCLES  = 700;      // long receiver hold-off
	localparam int IDLE_PCT     = 19;
	localparam logic signed [31:0] C_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

	// One result item: location, node index, status
	typedef struct packed {
		logic [31:0] location;
		logic [15:0] node;
		status_t     status;
	} peak_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;   // [31:0] node_coord, [63:32] sample_value
	logic        s_axis_tlast = 1'b0; // last_node
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;        // [31:0] peak_location, [47:32] peak_node,
	                                  // [49:48] peak_status
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Shadow of the window registers
	logic              win_en = 1'b0;
	logic signed [31:0] win_lo = C_MIN;
	logic signed [31:0] win_hi = C_MAX;

	// Search state of the predictor
	int                 scan_count;
	logic [31:0]        top_mag;
	int                 top_idx;
	logic signed [31:0] prior_coord, prior_value;
	logic signed [31:0] trio_coord [3];
	logic signed [31:0] trio_value [3];
	logic               right_pending;

	peak_result_t peak_expect_q [$];
	int  failures = 0;
	bit  idle_on = 1'b0;
	int  hold_requests = 0;
	int  hold_seen = 0;
	int  hold_left = 0;

	peak_abs_parabolic_locator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// Run limit
	initial begin
		#36000000;
		$display("** peak_abs_parabolic_locator_unit: FAILED **");
		$finish;
	end

	// |v|, most negative value clips to the largest positive one
	function automatic logic [31:0] magnitude(input logic signed [31:0] v);
		if (v == C_MIN)
			return 32'h7fff_ffff;
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic void clear_search();
		scan_count    = 0;
		top_mag       = '0;
		top_idx       = 0;
		prior_coord   = '0;
		prior_value   = '0;
		right_pending = 1'b0;
		for (int i = 0; i < 3; i++) begin
			trio_coord[i] = '0;
			trio_value[i] = '0;
		end
	endfunction

	// Vertex of the parabola through the kept triple, exact wide arithmetic
	function automatic void vertex_of_trio(output logic [31:0] loc, output status_t st);
		logic signed [129:0] x1, x2, x3, f1, f2, f3, a, b, p, q, den, num, off, pos;
		logic [129:0] num_mag, den_mag, quo;
		x1 = trio_coord[0];
		x2 = trio_coord[1];
		x3 = trio_coord[2];
		f1 = {98'd0, magnitude(trio_value[0])};
		f2 = {98'd0, magnitude(trio_value[1])};
		f3 = {98'd0, magnitude(trio_value[2])};
		a = x2 - x1;
		b = x2 - x3;
		p = f2 - f3;
		q = f2 - f1;
		den = a * p - b * q;
		num = a * a * p - b * b * q;
		if (den == 0) begin
			st  = ST_ZERO_DEN;
			loc = (num > 0) ? C_MIN : C_MAX;
			return;
		end
		st = ST_INTERP;
		num_mag = (num < 0) ? -num : num;
		den_mag = (den < 0) ? -(den * 2) : den * 2;
		quo = num_mag / den_mag;
		if (quo > 130'h2_0000_0000)
			quo = 130'h2_0000_0000;
		off = ((num < 0) != (den < 0)) ? -$signed(quo) : $signed(quo);
		pos = x2 - off;
		if (pos > C_MAX)
			pos = C_MAX;
		if (pos < C_MIN)
			pos = C_MIN;
		loc = pos[31:0];
	endfunction

	// Predictor: update the search with one accepted node, queue a result on the last
	function automatic void peak_track(input logic signed [31:0] coord,
			input logic signed [31:0] value, input logic is_last);
		logic [31:0]  mag;
		logic         in_window;
		peak_result_t res;
		if (scan_count < NODE_LIMIT) begin
			mag = magnitude(value);
			in_window = !win_en || (coord >= win_lo && coord <= win_hi);
			if (scan_count == 0) begin
				trio_coord[1] = coord;
				trio_value[1] = value;
			end
			if (in_window && mag > top_mag) begin
				top_mag       = mag;
				top_idx       = scan_count;
				trio_coord[0] = prior_coord;
				trio_value[0] = prior_value;
				trio_coord[1] = coord;
				trio_value[1] = value;
				right_pending = 1'b1;
			end else if (right_pending) begin
				trio_coord[2] = coord;
				trio_value[2] = value;
				right_pending = 1'b0;
			end
			prior_coord = coord;
			prior_value = value;
			scan_count++;
		end
		if (!is_last)
			return;
		res.node = top_idx[15:0];
		if (top_idx == 0 || top_idx == scan_count - 1) begin
			res.status   = ST_END_NODE;
			res.location = trio_coord[1];
		end else begin
			vertex_of_trio(res.location, res.status);
		end
		peak_expect_q = {peak_expect_q, res};
		clear_search();
	endfunction

	// Result checker
	always @(posedge clk) begin
		peak_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (peak_expect_q.size() == 0) begin
				$error("unexpected result item: %h", m_axis_tdata);
				failures++;
			end else begin
				want = peak_expect_q.pop_front();
				if (m_axis_tdata[31:0] !== want.location) begin
					$error("peak_location: expected %0d, got %0d",
						$signed(want.location), $signed(m_axis_tdata[31:0]));
					failures++;
				end
				if (m_axis_tdata[47:32] !== want.node) begin
					$error("peak_node: expected %0d, got %0d",
						want.node, m_axis_tdata[47:32]);
					failures++;
				end
				if (m_axis_tdata[49:48] !== want.status) begin
					$error("peak_status: expected %0d, got %0d",
						want.status, m_axis_tdata[49:48]);
					failures++;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Offer one node and wait until it is taken
	task automatic send_node(input logic signed [31:0] coord,
			input logic signed [31:0] value, input logic is_last);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {value, coord};
		s_axis_tlast  <= is_last;
		do @(posedge clk); while (!s_axis_tready);
		peak_track(coord, value, is_last);
	endtask

	task automatic stream_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;
	endtask

	// Wait until every expected result is out and the sequencer has gone quiet
	task automatic drain();
		stream_idle();
		while (peak_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_WIN_EN:   win_en = data[0];
			REG_WIN_LOW:  win_lo = data;
			REG_WIN_HIGH: win_hi = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_window(input logic en, input logic [31:0] lo, input logic [31:0] hi);
		drain();
		write_reg(REG_WIN_EN, {31'd0, en});
		write_reg(REG_WIN_LOW, lo);
		write_reg(REG_WIN_HIGH, hi);
	endtask

	// Three-node mesh
	task automatic send_trio(input logic [31:0] c0, v0, c1, v1, c2, v2);
		send_node(c0, v0, 1'b0);
		send_node(c1, v1, 1'b0);
		send_node(c2, v2, 1'b1);
	endtask

	function automatic logic [31:0] odd_value();
		case ($urandom_range(0, 5))
			0: return C_MIN;
			1: return C_MAX;
			2: return 32'd0;
			3: return 32'hffff_ffff;
			4: return 32'd1;
			default: return 32'h8000_0001;
		endcase
	endfunction

	function automatic int mesh_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return $urandom_range(1, 2);
		if (r < 90)
			return $urandom_range(3, 10);
		return $urandom_range(11, 48);
	endfunction

	// One mesh: a smooth bump with random content, or plain noise
	task automatic send_mesh(input int len, input bit shaped,
			input longint base_lo, input longint base_hi);
		longint base, step, amp, slope, v;
		int     peak_at, gap;
		logic [31:0] coord, value;
		base    = base_lo + longint'($urandom_range(0, 32'(base_hi - base_lo)));
		step    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1 << 16);
		amp     = $urandom_range(0, 32'h7fff_ffff);
		slope   = $urandom_range(0, 1 << 22);
		peak_at = $urandom_range(0, len - 1);
		for (int i = 0; i < len; i++) begin
			if (shaped) begin
				gap   = (i > peak_at) ? i - peak_at : peak_at - i;
				v     = amp - gap * slope;
				if (v < 0)
					v = $urandom_range(0, 255);
				if ($urandom_range(0, 2) == 0)
					v = -v;
				value = ($urandom_range(0, 15) == 0) ? odd_value() : 32'(v);
				coord = 32'(base + i * step);
			end else begin
				value = $urandom;
				coord = $urandom;
			end
			send_node(coord, value, i == len - 1);
		end
	endtask

	task automatic run_meshes(input int items, input longint base_lo, input longint base_hi);
		int sent, len;
		sent = 0;
		while (sent < items) begin
			len = mesh_length();
			send_mesh(len, $urandom_range(0, 99) < 80, base_lo, base_hi);
			sent += len;
		end
	endtask

	// Single node, all-zero values, peak on the last node
	task automatic test_end_node();
		send_node(C_MAX, C_MIN, 1'b1);
		send_trio(-32'sd5, 32'd0, 32'd0, 32'd0, 32'd5, 32'd0);
		send_trio(32'd0, 32'd1, 32'd1, 32'd2, 32'd2, 32'd3);
	endtask

	// Interior peaks, saturating magnitude and extreme coordinates
	task automatic test_interior_peak();
		send_trio(C_MIN, 32'd100, 32'd0, C_MIN, C_MAX, -32'sd7);
		send_trio(C_MAX, 32'd99, C_MIN + 5, 32'd100, C_MAX - 1, -32'sd99);
		send_trio(32'h0, 32'h8000, 32'h1_0000, 32'h3_0000, 32'h2_0000, 32'h2_8000);
	endtask

	// Degenerate triples: both signs of the numerator
	task automatic test_zero_denominator();
		send_trio(32'd9, 32'd9, 32'd10, 32'd10, 32'd8, 32'd8);
		send_trio(32'd8, 32'd8, 32'd10, -32'sd10, 32'd9, 32'd9);
		send_trio(32'd7, 32'd1, 32'd7, 32'd5, 32'd7, -32'sd2);
	endtask

	// Window: outside nodes serve only as neighbours; an empty window
	task automatic test_window();
		set_window(1'b1, -32'sd100, 32'sd100);
		send_node(-32'sd200, 32'd1000, 1'b0);
		send_node(-32'sd50, 32'd10, 1'b0);
		send_node(32'd0, -32'sd30, 1'b0);
		send_node(32'd50, 32'd20, 1'b0);
		send_node(32'd200, 32'd5000, 1'b1);
		set_window(1'b1, C_MAX, C_MIN);
		send_trio(32'd1, 32'd5, 32'd2, 32'd9, 32'd3, 32'd3);
		set_window(1'b0, C_MIN, C_MAX);
	endtask

	// Longer mesh with one strong peak deep inside
	task automatic test_long_mesh();
		logic [31:0] value;
		for (int i = 0; i < LONG_MESH; i++) begin
			value = (i == 150) ? 32'd1_000_000 : $urandom_range(0, 1000);
			send_node(32'(i * 3 - 100000), value, i == LONG_MESH - 1);
		end
	endtask

	// Receiver holds off while meshes keep coming, so the input stalls
	task automatic test_output_stall();
		hold_requests++;
		for (int i = 0; i < 15; i++)
			send_mesh(4, 1'b1, -(1 << 20), 1 << 20);
		drain();
	endtask

	// Random meshes through several window settings
	task automatic test_random_streams();
		longint lo;
		idle_on = 1'b0;
		run_meshes(380, -(longint'(1) << 31), (longint'(1) << 30));
		idle_on = 1'b1;
		lo = -longint'($urandom_range(0, 1 << 20));
		set_window(1'b1, 32'(lo), 32'(lo + $urandom_range(0, 1 << 21)));
		run_meshes(420, lo - (1 << 20), lo + (1 << 20));
		set_window(1'b1, C_MIN, C_MAX);
		run_meshes(380, -(longint'(1) << 31), (longint'(1) << 30));
		set_window(1'b0, $urandom, $urandom);
		run_meshes(420, -(longint'(1) << 31), (longint'(1) << 30));
		set_window(1'b0, C_MIN, C_MAX);
	endtask

	initial begin
		clear_search();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_end_node();
		idle_on = 1'b1;
		test_interior_peak();
		test_zero_denominator();
		test_window();
		test_long_mesh();
		idle_on = 1'b0;
		test_output_stall();
		test_random_streams();

		drain();
		if (failures == 0 && peak_expect_q.size() == 0)
			$display("** peak_abs_parabolic_locator_unit: PASSED **");
		else
			$display("** peak_abs_parabolic_locator_unit: FAILED **");
		$finish;
	end

endmodule
